// File: src/ccs_pkg.sv
// Package of shared types and constants for the C comment stripper.
package ccs_pkg;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_NL     = 8'h0A;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        MODE_CODE       = 3'd0,
        MODE_STR        = 3'd1,
        MODE_STR_ESC    = 3'd2,
        MODE_CHR        = 3'd3,
        MODE_CHR_ESC    = 3'd4,
        MODE_LINE       = 3'd5,
        MODE_BLOCK      = 3'd6,
        MODE_BLOCK_STAR = 3'd7
    } lex_mode_t;

    // One queued emit command: a character, optionally preceded by a held slash.
    typedef struct packed {
        logic       slash_first;
        logic [7:0] ch;
    } emit_cmd_t;

endpackage

// File: src/ccs_front.sv
// Front end: lexer state machine that classifies each character into an emit command.
module ccs_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 kind,
    input  logic [7:0]           char_code,
    input  logic                 queue_full,
    output logic                 in_stall,
    output logic                 push,
    output ccs_pkg::emit_cmd_t   push_cmd
);

    ccs_pkg::lex_mode_t mode_reg;
    ccs_pkg::lex_mode_t mode_next;
    logic               slash_reg;
    logic               slash_next;
    logic               accept;
    logic               emit_any;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= ccs_pkg::MODE_CODE;
            slash_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            slash_reg <= slash_next;
        end
    end

    // Next state.
    always_comb
    begin
        mode_next  = mode_reg;
        slash_next = slash_reg;
        if (kind == ccs_pkg::KIND_END)
        begin
            mode_next  = ccs_pkg::MODE_CODE;
            slash_next = 1'b0;
        end
        else
        begin
            case (mode_reg)
                ccs_pkg::MODE_CODE:
                begin
                    if (slash_reg)
                    begin
                        slash_next = 1'b0;
                        if (char_code == ccs_pkg::CH_SLASH)
                            mode_next = ccs_pkg::MODE_LINE;
                        else if (char_code == ccs_pkg::CH_STAR)
                            mode_next = ccs_pkg::MODE_BLOCK;
                        else if (char_code == ccs_pkg::CH_DQUOTE)
                            mode_next = ccs_pkg::MODE_STR;
                        else if (char_code == ccs_pkg::CH_SQUOTE)
                            mode_next = ccs_pkg::MODE_CHR;
                    end
                    else if (char_code == ccs_pkg::CH_SLASH)
                        slash_next = 1'b1;
                    else if (char_code == ccs_pkg::CH_DQUOTE)
                        mode_next = ccs_pkg::MODE_STR;
                    else if (char_code == ccs_pkg::CH_SQUOTE)
                        mode_next = ccs_pkg::MODE_CHR;
                end
                ccs_pkg::MODE_STR:
                begin
                    if (char_code == ccs_pkg::CH_BSLASH)
                        mode_next = ccs_pkg::MODE_STR_ESC;
                    else if (char_code == ccs_pkg::CH_DQUOTE)
                        mode_next = ccs_pkg::MODE_CODE;
                end
                ccs_pkg::MODE_STR_ESC:
                    mode_next = ccs_pkg::MODE_STR;
                ccs_pkg::MODE_CHR:
                begin
                    if (char_code == ccs_pkg::CH_BSLASH)
                        mode_next = ccs_pkg::MODE_CHR_ESC;
                    else if (char_code == ccs_pkg::CH_SQUOTE)
                        mode_next = ccs_pkg::MODE_CODE;
                end
                ccs_pkg::MODE_CHR_ESC:
                    mode_next = ccs_pkg::MODE_CHR;
                ccs_pkg::MODE_LINE:
                begin
                    if (char_code == ccs_pkg::CH_NL)
                        mode_next = ccs_pkg::MODE_CODE;
                end
                ccs_pkg::MODE_BLOCK:
                begin
                    if (char_code == ccs_pkg::CH_STAR)
                        mode_next = ccs_pkg::MODE_BLOCK_STAR;
                end
                ccs_pkg::MODE_BLOCK_STAR:
                begin
                    if (char_code == ccs_pkg::CH_SLASH)
                        mode_next = ccs_pkg::MODE_CODE;
                    else if (char_code != ccs_pkg::CH_STAR)
                        mode_next = ccs_pkg::MODE_BLOCK;
                end
                default:
                    mode_next = ccs_pkg::MODE_CODE;
            endcase
        end
    end

    // Outputs: decide what, if anything, this character puts into the queue.
    always_comb
    begin
        emit_any             = 1'b0;
        push_cmd.slash_first = 1'b0;
        push_cmd.ch          = char_code;
        if (kind == ccs_pkg::KIND_END)
        begin
            emit_any    = (mode_reg == ccs_pkg::MODE_CODE) && slash_reg;
            push_cmd.ch = ccs_pkg::CH_SLASH;
        end
        else
        begin
            case (mode_reg)
                ccs_pkg::MODE_CODE:
                begin
                    if (slash_reg)
                    begin
                        emit_any             = !(char_code inside {ccs_pkg::CH_SLASH,
                                                                   ccs_pkg::CH_STAR});
                        push_cmd.slash_first = 1'b1;
                    end
                    else
                        emit_any = (char_code != ccs_pkg::CH_SLASH);
                end
                ccs_pkg::MODE_STR, ccs_pkg::MODE_STR_ESC,
                ccs_pkg::MODE_CHR, ccs_pkg::MODE_CHR_ESC:
                    emit_any = 1'b1;
                ccs_pkg::MODE_LINE, ccs_pkg::MODE_BLOCK, ccs_pkg::MODE_BLOCK_STAR:
                    emit_any = (char_code == ccs_pkg::CH_NL);
                default:
                    emit_any = 1'b0;
            endcase
        end
    end

    assign push = accept && emit_any;

endmodule

// File: src/ccs_queue.sv
// Short command queue between the lexer front end and the output back end.
module ccs_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  ccs_pkg::emit_cmd_t   push_cmd,
    input  logic                 pop,
    output ccs_pkg::emit_cmd_t   head_cmd,
    output logic                 empty,
    output logic                 full
);

    localparam logic [ccs_pkg::QUEUE_AW-1:0] LAST_PTR =
        ccs_pkg::QUEUE_AW'(ccs_pkg::QUEUE_DEPTH - 1);
    localparam logic [ccs_pkg::QUEUE_CW-1:0] FULL_CNT =
        ccs_pkg::QUEUE_CW'(ccs_pkg::QUEUE_DEPTH);

    ccs_pkg::emit_cmd_t                 slot_reg [ccs_pkg::QUEUE_DEPTH];
    logic [ccs_pkg::QUEUE_AW-1:0]       wr_ptr_reg;
    logic [ccs_pkg::QUEUE_AW-1:0]       wr_ptr_next;
    logic [ccs_pkg::QUEUE_AW-1:0]       rd_ptr_reg;
    logic [ccs_pkg::QUEUE_AW-1:0]       rd_ptr_next;
    logic [ccs_pkg::QUEUE_CW-1:0]       count_reg;
    logic [ccs_pkg::QUEUE_CW-1:0]       count_next;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == FULL_CNT);
    assign head_cmd = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// File: src/ccs_back.sv
// Back end: expands queued commands into output characters through an output register.
module ccs_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ccs_pkg::emit_cmd_t   head_cmd,
    input  logic                 empty,
    output logic                 pop,
    input  logic                 out_stall,
    output logic                 out_valid,
    output logic [7:0]           text_char,
    output logic                 last
);

    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_char_reg;
    logic [7:0] out_char_next;
    logic       out_last_reg;
    logic       out_last_next;
    logic       pend_reg;
    logic       pend_next;
    logic [7:0] pend_char_reg;
    logic [7:0] pend_char_next;
    logic       out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        pend_next      = pend_reg;
        pend_char_next = pend_char_reg;
        pop            = 1'b0;
        if (out_free)
        begin
            if (pend_reg)
            begin
                out_valid_next = 1'b1;
                out_char_next  = pend_char_reg;
                out_last_next  = 1'b1;
                pend_next      = 1'b0;
            end
            else if (!empty)
            begin
                pop            = 1'b1;
                out_valid_next = 1'b1;
                if (head_cmd.slash_first)
                begin
                    out_char_next  = ccs_pkg::CH_SLASH;
                    out_last_next  = 1'b0;
                    pend_next      = 1'b1;
                    pend_char_next = head_cmd.ch;
                end
                else
                begin
                    out_char_next = head_cmd.ch;
                    out_last_next = 1'b1;
                end
            end
            else
                out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_char_reg  <= out_char_next;
        out_last_reg  <= out_last_next;
        pend_char_reg <= pend_char_next;
    end

    assign out_valid = out_valid_reg;
    assign text_char = out_char_reg;
    assign last      = out_last_reg;

endmodule

// File: src/c_comment_stripper_core.sv
// Top level of the C comment stripper: front end, command queue and back end.
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+-----------------------
//  in      | into core | in_valid / in_stall  | kind, char_code
//  out     | from core | out_valid / out_stall| text_char, last
//
// One input transfer is taken in every cycle while the four-entry command queue
// has room; in_stall is simply the queue's full flag.
// A character that releases a held slash yields two output transfers; the
// queue absorbs such bursts. Each result is registered in the command queue
// and then in the output register before it leaves the core.
// rst_n is asynchronous and active low; it returns the lexer to code mode with
// no slash held and empties the queue and the output register.
// Stalls on either side are independent: a stalled output only blocks the input
// once the queue has filled.
module c_comment_stripper_core
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       kind,
    input  logic [7:0] char_code,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] text_char,
    output logic       last
);

    ccs_pkg::emit_cmd_t push_cmd;
    ccs_pkg::emit_cmd_t head_cmd;
    logic               push;
    logic               pop;
    logic               queue_empty;
    logic               queue_full;

    // The front end runs the lexer and turns each accepted character into at
    // most one queued command.
    ccs_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .kind       (kind),
        .char_code  (char_code),
        .queue_full (queue_full),
        .in_stall   (in_stall),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    // The queue decouples the lexer from the output side.
    ccs_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .empty    (queue_empty),
        .full     (queue_full)
    );

    // The back end expands a command into one or two output transfers and
    // marks the final one with last.
    ccs_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_cmd  (head_cmd),
        .empty     (queue_empty),
        .pop       (pop),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .text_char (text_char),
        .last      (last)
    );

endmodule

// File: src/ccs_checker.sv
// Port-level checker for the C comment stripper, bound to the top level.
module ccs_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] text_char,
    input logic       last
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(text_char) && $stable(last))
        else $error("stalled output transfer changed");

    // The first of a pair of results is always the released slash.
    a_pair_slash: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> text_char == ccs_pkg::CH_SLASH)
        else $error("non-final result is not a slash");

    // A non-final result is always followed by a further result.
    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |=> out_valid)
        else $error("second result of a pair went missing");

    // Once the slash is taken, the second result comes at once and is final.
    a_pair_next: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last && !out_stall |=> out_valid && last)
        else $error("second result of a pair not presented next cycle");

endmodule

bind c_comment_stripper_core ccs_checker u_ccs_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .text_char (text_char),
    .last      (last)
);

// File: test/tb_top.sv
// Self-checking testbench for the C comment stripper core.
`timescale 1ns / 1ps

module tb_top;

    // One source transfer as the driver presents it.
    typedef struct packed {
        logic       kind;
        logic [7:0] char_code;
    } src_item_t;

    // One expected output transfer.
    typedef struct packed {
        logic [7:0] text_char;
        logic       last;
    } text_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       kind = ccs_pkg::KIND_CHAR;
    logic [7:0] char_code = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] text_char;
    logic       last;

    src_item_t    src_pending[$];
    text_result_t text_expected[$];
    text_result_t want;

    // Lexer state as the testbench tracks it, advanced once per accepted input transfer.
    ccs_pkg::lex_mode_t lex_state = ccs_pkg::MODE_CODE;
    logic               slash_pending = 1'b0;

    int items_sent = 0;
    int results_seen = 0;
    int fail_count = 0;

    c_comment_stripper_core u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .char_code (char_code),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .text_char (text_char),
        .last      (last)
    );

    always #5 clk = ~clk;

    // Works out the text that one input transfer releases and queues it, the
    // final character of the transfer carrying the last flag.
    function void predict_text(input logic k, input logic [7:0] c);
        logic [7:0] outs [2];
        int         n;
        logic       plain;
        n = 0;
        plain = 1'b0;
        if (k == ccs_pkg::KIND_END) begin
            // A held slash is flushed; everything else simply returns to code mode.
            if (lex_state == ccs_pkg::MODE_CODE && slash_pending) begin
                outs[n] = ccs_pkg::CH_SLASH;
                n = n + 1;
            end
            lex_state = ccs_pkg::MODE_CODE;
            slash_pending = 1'b0;
        end
        else begin
            case (lex_state)
                ccs_pkg::MODE_CODE:
                begin
                    if (slash_pending) begin
                        slash_pending = 1'b0;
                        if (c == ccs_pkg::CH_SLASH)
                            lex_state = ccs_pkg::MODE_LINE;
                        else if (c == ccs_pkg::CH_STAR)
                            lex_state = ccs_pkg::MODE_BLOCK;
                        else begin
                            // The held slash was a division after all.
                            outs[n] = ccs_pkg::CH_SLASH;
                            n = n + 1;
                            plain = 1'b1;
                        end
                    end
                    else if (c == ccs_pkg::CH_SLASH)
                        slash_pending = 1'b1;
                    else
                        plain = 1'b1;
                    if (plain) begin
                        if (c == ccs_pkg::CH_DQUOTE)
                            lex_state = ccs_pkg::MODE_STR;
                        else if (c == ccs_pkg::CH_SQUOTE)
                            lex_state = ccs_pkg::MODE_CHR;
                        outs[n] = c;
                        n = n + 1;
                    end
                end
                ccs_pkg::MODE_STR:
                begin
                    outs[n] = c;
                    n = n + 1;
                    if (c == ccs_pkg::CH_BSLASH)
                        lex_state = ccs_pkg::MODE_STR_ESC;
                    else if (c == ccs_pkg::CH_DQUOTE)
                        lex_state = ccs_pkg::MODE_CODE;
                end
                ccs_pkg::MODE_STR_ESC:
                begin
                    outs[n] = c;
                    n = n + 1;
                    lex_state = ccs_pkg::MODE_STR;
                end
                ccs_pkg::MODE_CHR:
                begin
                    outs[n] = c;
                    n = n + 1;
                    if (c == ccs_pkg::CH_BSLASH)
                        lex_state = ccs_pkg::MODE_CHR_ESC;
                    else if (c == ccs_pkg::CH_SQUOTE)
                        lex_state = ccs_pkg::MODE_CODE;
                end
                ccs_pkg::MODE_CHR_ESC:
                begin
                    outs[n] = c;
                    n = n + 1;
                    lex_state = ccs_pkg::MODE_CHR;
                end
                ccs_pkg::MODE_LINE:
                begin
                    // Only the newline that closes the comment survives.
                    if (c == ccs_pkg::CH_NL) begin
                        outs[n] = c;
                        n = n + 1;
                        lex_state = ccs_pkg::MODE_CODE;
                    end
                end
                ccs_pkg::MODE_BLOCK:
                begin
                    if (c == ccs_pkg::CH_STAR)
                        lex_state = ccs_pkg::MODE_BLOCK_STAR;
                    else if (c == ccs_pkg::CH_NL) begin
                        outs[n] = c;
                        n = n + 1;
                    end
                end
                default:
                begin
                    // After a star: a slash closes, further stars keep waiting.
                    if (c == ccs_pkg::CH_SLASH)
                        lex_state = ccs_pkg::MODE_CODE;
                    else if (c != ccs_pkg::CH_STAR) begin
                        lex_state = ccs_pkg::MODE_BLOCK;
                        if (c == ccs_pkg::CH_NL) begin
                            outs[n] = c;
                            n = n + 1;
                        end
                    end
                end
            endcase
        end
        for (int i = 0; i < n; i++)
            text_expected.push_back('{text_char: outs[i], last: (i == n - 1)});
    endfunction

    function void push_byte(input logic [7:0] c);
        src_pending.push_back('{kind: ccs_pkg::KIND_CHAR, char_code: c});
    endfunction

    function void push_end();
        // The character field is ignored here, so it carries noise.
        src_pending.push_back('{kind: ccs_pkg::KIND_END,
                                char_code: 8'($urandom_range(0, 255))});
    endfunction

    function void push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endfunction

    // A byte biased towards the characters that drive the lexer.
    function logic [7:0] pick_byte();
        logic [7:0] b;
        case ($urandom_range(0, 11))
            0:       b = ccs_pkg::CH_SLASH;
            1:       b = ccs_pkg::CH_STAR;
            2:       b = ccs_pkg::CH_NL;
            3:       b = ccs_pkg::CH_BSLASH;
            4:       b = ccs_pkg::CH_DQUOTE;
            5:       b = ccs_pkg::CH_SQUOTE;
            default: b = 8'($urandom_range(0, 255));
        endcase
        return b;
    endfunction

    // Stimulus: a directed opening, then mostly well-formed C fragments with
    // random contents, some raw noise and the odd end-of-input marker.
    initial begin
        logic [7:0] b;
        logic [7:0] prev;
        logic [7:0] quote;
        int         n;

        push_byte(8'h00);
        push_byte(8'hFF);
        push_text("/x");            // held slash released ahead of an ordinary byte
        push_text("'\n\\''");       // newline and escaped quote inside a char literal
        push_text("\"/*\\\"\"");    // comment opener and escaped quote inside a string
        push_text("//\\\n");        // backslash before newline does not continue the comment
        push_text("/*\n**/");       // newline kept, run of stars before the closing slash
        push_text("/");
        push_end();                 // held slash flushed by end of input
        push_text("'");
        push_end();                 // end of input inside an open literal
        push_end();                 // end of input with nothing pending

        while (src_pending.size() < 1575) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3:
                begin
                    n = $urandom_range(1, 6);
                    for (int i = 0; i < n; i++) begin
                        b = pick_byte();
                        if (b == ccs_pkg::CH_SLASH || b == ccs_pkg::CH_DQUOTE ||
                            b == ccs_pkg::CH_SQUOTE)
                            b = 8'h3B;
                        push_byte(b);
                    end
                end
                4, 5, 6, 7, 8:
                begin
                    quote = ($urandom_range(0, 2) == 0) ? ccs_pkg::CH_SQUOTE
                                                        : ccs_pkg::CH_DQUOTE;
                    push_byte(quote);
                    n = $urandom_range(0, 8);
                    for (int i = 0; i < n; i++) begin
                        if ($urandom_range(0, 4) == 0) begin
                            push_byte(ccs_pkg::CH_BSLASH);
                            push_byte(pick_byte());
                        end
                        else begin
                            b = pick_byte();
                            if (b == quote || b == ccs_pkg::CH_BSLASH)
                                b = 8'h61;
                            push_byte(b);
                        end
                    end
                    push_byte(quote);
                end
                9, 10, 11:
                begin
                    push_text("//");
                    n = $urandom_range(0, 10);
                    for (int i = 0; i < n; i++) begin
                        b = pick_byte();
                        push_byte((b == ccs_pkg::CH_NL) ? 8'h78 : b);
                    end
                    push_byte(ccs_pkg::CH_NL);
                end
                12, 13, 14:
                begin
                    push_text("/*");
                    prev = 8'h00;
                    n = $urandom_range(0, 12);
                    for (int i = 0; i < n; i++) begin
                        b = pick_byte();
                        // Keep the comment open until the chosen closing run.
                        if (prev == ccs_pkg::CH_STAR && b == ccs_pkg::CH_SLASH)
                            b = ccs_pkg::CH_NL;
                        push_byte(b);
                        prev = b;
                    end
                    n = $urandom_range(1, 3);
                    for (int i = 0; i < n; i++)
                        push_byte(ccs_pkg::CH_STAR);
                    push_byte(ccs_pkg::CH_SLASH);
                end
                15, 16:
                begin
                    push_byte(ccs_pkg::CH_SLASH);
                    b = pick_byte();
                    if (b == ccs_pkg::CH_SLASH || b == ccs_pkg::CH_STAR)
                        b = 8'h20;
                    push_byte(b);
                end
                17, 18:
                begin
                    n = $urandom_range(1, 4);
                    for (int i = 0; i < n; i++)
                        push_byte(8'($urandom_range(0, 255)));
                end
                default:
                    push_end();
            endcase
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Sample away from the rising edge so that driver updates have settled.
        while (src_pending.size() != 0 || in_valid)
            @(negedge clk);
        while (text_expected.size() != 0)
            @(negedge clk);
        repeat (16) @(negedge clk);

        if (text_expected.size() != 0) begin
            fail_count++;
            $display("%0t: %0d expected transfers never arrived", $time, text_expected.size());
        end
        if (fail_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // Input driver: an offered transfer is held until taken, and the prediction
    // is made at the edge that takes it.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid  <= 1'b0;
            kind      <= ccs_pkg::KIND_CHAR;
            char_code <= 8'h00;
        end
        else begin
            if (in_valid && !in_stall) begin
                predict_text(kind, char_code);
                items_sent++;
            end
            if (!in_valid || !in_stall) begin
                // A stretch of the run goes without input gaps.
                if (src_pending.size() != 0 &&
                    ((items_sent >= 700 && items_sent < 1000) ||
                     $urandom_range(0, 99) >= 30)) begin
                    in_valid  <= 1'b1;
                    kind      <= src_pending[0].kind;
                    char_code <= src_pending[0].char_code;
                    void'(src_pending.pop_front());
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Output monitor: each transfer is checked against the oldest expectation.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            out_stall <= 1'b0;
        else begin
            if (out_valid && !out_stall) begin
                results_seen++;
                if (text_expected.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected transfer text_char=%h last=%b",
                             $time, text_char, last);
                end
                else begin
                    want = text_expected.pop_front();
                    if (text_char !== want.text_char) begin
                        fail_count++;
                        $display("%0t: text_char expected %h actual %h",
                                 $time, want.text_char, text_char);
                    end
                    if (last !== want.last) begin
                        fail_count++;
                        $display("%0t: last expected %b actual %b",
                                 $time, want.last, last);
                    end
                end
            end
            out_stall <= !(results_seen >= 200 && results_seen < 500) &&
                         ($urandom_range(0, 99) < 30);
        end
    end

    initial begin
        #2_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule
